[hdl/dsrs_pkg.sv]
// ----------------------------------------------------------------------------
// Download shortest-remaining scheduler package
// Shared types and constants for the controller, the datapath and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package dsrs_pkg;

  localparam int ID_W     = 16;
  localparam int BYTES_W  = 32;
  localparam int SECS_W   = 16;
  localparam int COUNT_W  = 5;
  localparam int BUDGET_W = SECS_W + BYTES_W;
  localparam logic [BYTES_W-1:0] BANDWIDTH_RESET = 32'd1024;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RD_TAIL  = 2'd0,
    RD_SHIFT = 2'd1,
    RD_HEAD  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    idx_load;
    logic    shift_wr;
    logic    put_wr;
    logic    rem_wr;
    logic    pop;
    logic    emit;
    kind_t   kind;
  } dp_cmd_t;

  typedef struct packed {
    logic in_wait;
    logic full;
    logic empty;
    logic idx_is_one;
    logic rem_ge;
    logic budget_zero;
    logic head_fits;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[hdl/dsrs_ctrl.sv]
// ----------------------------------------------------------------------------
// Download shortest-remaining scheduler controller
// Sequences insertion scans and budget spending over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dsrs_pkg::dp_sts_t sts,
  output dsrs_pkg::dp_cmd_t      cmd
);
  import dsrs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADD   = 6'b000010,
    S_SHIFT = 6'b000100,
    S_PUT   = 6'b001000,
    S_WCHK  = 6'b010000,
    S_WCMP  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    cmd.kind   = KIND_ACCEPT;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = sts.in_wait ? S_WCHK : S_ADD;
        end
      end
      S_ADD: begin
        if (sts.full) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.kind   = KIND_REJECT;
            state_next = S_IDLE;
          end
        end else begin
          cmd.idx_load = 1'b1;
          if (sts.empty) begin
            state_next = S_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_TAIL;
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (sts.rem_ge) begin
          cmd.shift_wr = 1'b1;
          if (sts.idx_is_one) begin
            state_next = S_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SHIFT;
          end
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.put_wr = 1'b1;
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_ACCEPT;
          state_next = S_IDLE;
        end
      end
      S_WCHK: begin
        if (sts.budget_zero || sts.empty) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.kind   = KIND_FINISH;
            state_next = S_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_next = S_WCMP;
        end
      end
      S_WCMP: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.head_fits) begin
            cmd.pop    = 1'b1;
            cmd.kind   = KIND_DONE;
            state_next = S_WCHK;
          end else begin
            cmd.rem_wr = 1'b1;
            cmd.kind   = KIND_FINISH;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/dsrs_dp.sv]
// ----------------------------------------------------------------------------
// Download shortest-remaining scheduler datapath
// Circular queue memory, request registers, budget and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsrs_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [dsrs_pkg::BYTES_W-1:0]  cfg_data,
  input  wire logic                          req_type,
  input  wire logic [dsrs_pkg::ID_W-1:0]     res_id,
  input  wire logic [dsrs_pkg::BYTES_W-1:0]  res_size,
  input  wire logic [dsrs_pkg::BYTES_W-1:0]  res_done,
  input  wire logic [dsrs_pkg::SECS_W-1:0]   seconds,
  input  wire dsrs_pkg::dp_cmd_t             cmd,
  output dsrs_pkg::dp_sts_t                  sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dsrs_pkg::kind_t                    out_kind,
  output logic [dsrs_pkg::ID_W-1:0]          out_id,
  output logic [dsrs_pkg::COUNT_W-1:0]       out_count,
  output logic                               out_last
);
  import dsrs_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = AW + 1;

  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] h, input logic [LW-1:0] l);
    logic [LW-1:0] s;
    s = LW'(h) + l;
    if (s >= LW'(QUEUE_DEPTH)) begin
      s = s - LW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;

  logic [BYTES_W-1:0]  bandwidth;
  logic [ID_W-1:0]     in_id;
  logic [BYTES_W-1:0]  in_rem;
  logic [BUDGET_W-1:0] budget;
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       idx;
  logic [LW-1:0]       rd_logical;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;
  logic                wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      bandwidth <= BANDWIDTH_RESET;
    end else if (cfg_we) begin
      bandwidth <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_id  <= res_id;
      in_rem <= (res_done >= res_size) ? '0 : res_size - res_done;
      budget <= BUDGET_W'(seconds) * BUDGET_W'(bandwidth);
    end else if (cmd.pop) begin
      budget <= budget - BUDGET_W'(rd_data.rem);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_TAIL:  rd_logical = LW'(count) - LW'(1);
      RD_SHIFT: rd_logical = LW'(idx) - LW'(2);
      default:  rd_logical = '0;
    endcase
  end

  assign rd_addr = to_phys(head, rd_logical);
  assign wr_en   = cmd.shift_wr | cmd.put_wr | cmd.rem_wr;
  assign wr_addr = cmd.rem_wr ? head : to_phys(head, LW'(idx));

  always_comb begin
    if (cmd.shift_wr) begin
      wr_data = rd_data;
    end else if (cmd.put_wr) begin
      wr_data = '{id: in_id, rem: in_rem};
    end else begin
      wr_data = '{id: rd_data.id, rem: rd_data.rem - budget[BYTES_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_load) begin
      idx <= count;
    end else if (cmd.shift_wr) begin
      idx <= idx - CW'(1);
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.put_wr) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else begin
      count <= count_next;
      if (cmd.pop) begin
        head <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind  <= cmd.kind;
      out_count <= COUNT_W'(count_next);
      out_last  <= (cmd.kind != KIND_DONE);
      case (cmd.kind)
        KIND_ACCEPT, KIND_REJECT: out_id <= in_id;
        KIND_DONE:                out_id <= rd_data.id;
        default:                  out_id <= '0;
      endcase
    end
  end

  assign sts.in_wait     = req_type;
  assign sts.full        = (count == CW'(QUEUE_DEPTH));
  assign sts.empty       = (count == '0);
  assign sts.idx_is_one  = (idx == CW'(1));
  assign sts.rem_ge      = (rd_data.rem >= in_rem);
  assign sts.budget_zero = (budget == '0);
  assign sts.head_fits   = (BUDGET_W'(rd_data.rem) <= budget);
  assign sts.out_free    = ~out_valid | out_ready;

endmodule

`default_nettype wire

[hdl/download_shortest_remaining_scheduler.sv]
// ----------------------------------------------------------------------------
// Download shortest-remaining scheduler
// Queue of pending transfers kept in order of remaining bytes, with add and
// wait requests.
//
//   Channel  Handshake            Payload
//   cfg      cfg_we               cfg_data (bandwidth)
//   in       in_valid / in_ready  req_type, res_id, res_size, res_done, seconds
//   out      out_valid / out_ready kind, done_id, queue_count, last
//
// One request is worked at a time. An add shifts larger entries one by one in the
// backward insertion scan through the queue memory.
// A wait reads each head entry from the memory before it is compared with
// the budget, and retires entries that fit until the budget is spent.
// Reset empties the queue at once and sets the bandwidth to 1024.
// A stalled result register holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module download_shortest_remaining_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [dsrs_pkg::BYTES_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic [dsrs_pkg::ID_W-1:0]     res_id,
  input  wire logic [dsrs_pkg::BYTES_W-1:0]  res_size,
  input  wire logic [dsrs_pkg::BYTES_W-1:0]  res_done,
  input  wire logic [dsrs_pkg::SECS_W-1:0]   seconds,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         kind,
  output logic [dsrs_pkg::ID_W-1:0]          done_id,
  output logic [dsrs_pkg::COUNT_W-1:0]       queue_count,
  output logic                               last
);
  import dsrs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  kind_t   out_kind;

  dsrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsrs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .res_id    (res_id),
    .res_size  (res_size),
    .res_done  (res_done),
    .seconds   (seconds),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_id    (done_id),
    .out_count (queue_count),
    .out_last  (last)
  );

  assign kind = out_kind;

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shortest-remaining transfer queue testbench
// Sends add and wait requests through the request channel under random
// idling on both sides. Every accepted request is run through a local model
// of the queue, and each result from the block is compared with the oldest
// predicted one. Bandwidth is changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module testbench;

  import dsrs_pkg::*;

  localparam int QUEUE_SLOTS = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_STALL = 300;
  localparam int BATCH_ITEMS = 27;
  localparam logic [BYTES_W-1:0] BW_MAX = '1;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_WAIT = 1'b1
  } req_kind_t;

  typedef enum int {
    STYLE_PLAIN,
    STYLE_LONG_STALL,
    STYLE_NO_IDLE
  } phase_style_t;

  typedef struct {
    req_kind_t          op;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] size;
    logic [BYTES_W-1:0] done;
    logic [SECS_W-1:0]  secs;
  } request_t;

  typedef struct {
    kind_t              kind;
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
    logic               last_flag;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [BYTES_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [ID_W-1:0] res_id = '0;
  logic [BYTES_W-1:0] res_size = '0;
  logic [BYTES_W-1:0] res_done = '0;
  logic [SECS_W-1:0] seconds = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [ID_W-1:0] done_id;
  logic [COUNT_W-1:0] queue_count;
  logic last;

  logic [ID_W-1:0] sched_ids [QUEUE_SLOTS];
  logic [BYTES_W-1:0] sched_rem [QUEUE_SLOTS];
  int sched_count = 0;
  logic [BYTES_W-1:0] bw_setting = BANDWIDTH_RESET;

  request_t send_backlog [$];
  result_t due_results [$];
  request_t cur_req;

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int stall_order = 0;
  int send_gap = 0;
  int recv_wait = 0;
  int stall_left = 0;
  int stall_seen = 0;

  int cycle_count = 0;
  int fail_count = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int completions = 0;
  int rejections = 0;
  int wait_run = 0;
  int longest_run = 0;
  int bw_writes = 0;

  download_shortest_remaining_scheduler #(
    .QUEUE_DEPTH(QUEUE_SLOTS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .res_id     (res_id),
    .res_size   (res_size),
    .res_done   (res_done),
    .seconds    (seconds),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .done_id    (done_id),
    .queue_count(queue_count),
    .last       (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_wait(input bit enabled);
    if (!enabled || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic schedule_request(input request_t r);
    logic [BYTES_W-1:0] rem;
    logic [BUDGET_W-1:0] budget;
    logic [ID_W-1:0] cid;
    int pos;
    int i;
    if (r.op == REQ_ADD) begin
      rem = (r.done >= r.size) ? '0 : r.size - r.done;
      if (sched_count >= QUEUE_SLOTS) begin
        due_results.push_back(result_t'{KIND_REJECT, r.id, COUNT_W'(sched_count), 1'b1});
      end else begin
        pos = sched_count;
        for (i = sched_count - 1; i >= 0; i--) begin
          if (rem <= sched_rem[i]) pos = i;
        end
        for (i = sched_count; i > pos; i--) begin
          sched_ids[i] = sched_ids[i-1];
          sched_rem[i] = sched_rem[i-1];
        end
        sched_ids[pos] = r.id;
        sched_rem[pos] = rem;
        sched_count++;
        due_results.push_back(result_t'{KIND_ACCEPT, r.id, COUNT_W'(sched_count), 1'b1});
      end
    end else begin
      budget = BUDGET_W'(r.secs) * BUDGET_W'(bw_setting);
      while (budget != 0 && sched_count > 0) begin
        if (BUDGET_W'(sched_rem[0]) > budget) begin
          sched_rem[0] = sched_rem[0] - budget[BYTES_W-1:0];
          budget = '0;
        end else begin
          budget = budget - BUDGET_W'(sched_rem[0]);
          cid = sched_ids[0];
          for (i = 1; i < sched_count; i++) begin
            sched_ids[i-1] = sched_ids[i];
            sched_rem[i-1] = sched_rem[i];
          end
          sched_count--;
          due_results.push_back(result_t'{KIND_DONE, cid, COUNT_W'(sched_count), 1'b0});
        end
      end
      due_results.push_back(result_t'{KIND_FINISH, '0, COUNT_W'(sched_count), 1'b1});
    end
  endtask

  always @(posedge clk) begin : sender
    int gap_now;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        schedule_request(cur_req);
        requests_taken++;
      end
      gap_now = in_valid ? draw_wait(send_idle_on) : send_gap;
      if (gap_now == 0 && send_backlog.size() != 0) begin
        cur_req = send_backlog.pop_front();
        req_type <= cur_req.op;
        res_id <= cur_req.id;
        res_size <= cur_req.size;
        res_done <= cur_req.done;
        seconds <= cur_req.secs;
        in_valid <= 1'b1;
        send_gap <= 0;
      end else begin
        in_valid <= 1'b0;
        send_gap <= (gap_now > 0) ? gap_now - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    result_t want;
    int next_wait;
    int next_stall;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      stall_left <= 0;
      stall_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d, done_id %0h, queue_count %0d, last %0b",
                 kind, done_id, queue_count, last);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            fail_count++;
          end
          if (done_id !== want.id) begin
            $error("done_id: expected %0h, got %0h", want.id, done_id);
            fail_count++;
          end
          if (queue_count !== want.count) begin
            $error("queue_count: expected %0d, got %0d", want.count, queue_count);
            fail_count++;
          end
          if (last !== want.last_flag) begin
            $error("last: expected %0b, got %0b", want.last_flag, last);
            fail_count++;
          end
        end
        if (kind == KIND_DONE) completions++;
        if (kind == KIND_REJECT) rejections++;
        if (kind == KIND_DONE || kind == KIND_FINISH) begin
          if (wait_run + 1 > longest_run) longest_run = wait_run + 1;
          wait_run = (kind == KIND_DONE) ? wait_run + 1 : 0;
        end
      end
      next_wait = recv_wait;
      next_stall = stall_left;
      if (stall_seen != stall_order) begin
        stall_seen <= stall_order;
        next_stall = LONG_STALL;
      end
      if (out_valid && out_ready) begin
        next_wait = draw_wait(recv_idle_on);
      end else if (next_wait > 0) begin
        next_wait--;
      end
      if (next_stall > 0) next_stall--;
      recv_wait <= next_wait;
      stall_left <= next_stall;
      out_ready <= (next_wait == 0) && (next_stall == 0);
    end
  end

  function automatic request_t add_req(input logic [ID_W-1:0] id,
                                       input logic [BYTES_W-1:0] size,
                                       input logic [BYTES_W-1:0] done);
    add_req = '{REQ_ADD, id, size, done, '0};
  endfunction

  function automatic request_t wait_req(input logic [SECS_W-1:0] secs);
    wait_req = '{REQ_WAIT, '0, '0, '0, secs};
  endfunction

  function automatic request_t make_request(input int unsigned scale,
                                            input int unsigned max_secs);
    request_t r;
    int unsigned pick;
    logic [BYTES_W-1:0] delta;
    pick = $urandom_range(0, 99);
    r.id = ID_W'($urandom);
    r.size = $urandom;
    r.done = $urandom;
    r.secs = SECS_W'($urandom);
    delta = $urandom_range(0, scale);
    if (pick < 56) begin
      r.op = REQ_ADD;
      if (r.done > ~delta) r.done = r.done - delta;
      r.size = r.done + delta;
    end else if (pick < 64) begin
      r.op = REQ_ADD;
    end else if (pick < 68) begin
      r.op = REQ_ADD;
      r.size = r.done;
    end else begin
      r.op = REQ_WAIT;
      if (pick < 95) r.secs = SECS_W'($urandom_range(0, max_secs));
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (send_backlog.size() != 0 || in_valid || due_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bandwidth(input logic [BYTES_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    bw_setting = value;
    bw_writes++;
  endtask

  task automatic run_batch(input int unsigned scale, input int unsigned max_secs);
    int k;
    @(negedge clk);
    for (k = 0; k < BATCH_ITEMS; k++) begin
      send_backlog.push_back(make_request(scale, max_secs));
    end
    wait_idle();
  endtask

  task automatic flush_queue();
    set_bandwidth(BW_MAX);
    @(negedge clk);
    send_backlog.push_back(wait_req('1));
    wait_idle();
  endtask

  task automatic run_phase(input logic [BYTES_W-1:0] bw, input int unsigned scale,
                           input int unsigned max_secs, input phase_style_t style);
    set_bandwidth(bw);
    @(negedge clk);
    if (style == STYLE_NO_IDLE) begin
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
    end
    run_batch(scale, max_secs);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    if (style == STYLE_LONG_STALL) begin
      @(negedge clk);
      send_idle_on = 1'b0;
      stall_order++;
    end
    run_batch(scale, max_secs);
    send_idle_on = 1'b1;
    run_batch(scale, max_secs);
    flush_queue();
  endtask

  initial begin
    logic [BYTES_W-1:0] mid_bw;
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset bandwidth: empty wait, clamping, ties, zero budget, exact spend, full queue.
    send_backlog.push_back(wait_req(16'd1));
    send_backlog.push_back(add_req(16'hFFFF, 32'hFFFF_FFFF, 32'h0));
    send_backlog.push_back(add_req(16'h0000, 32'h0, 32'h0));
    send_backlog.push_back(add_req(16'h0001, 32'd100, 32'd200));
    send_backlog.push_back(add_req(16'h0002, 32'd2048, 32'd1024));
    send_backlog.push_back(add_req(16'h0003, 32'hFFFF_FFFF, 32'hFFFF_FBFF));
    send_backlog.push_back(wait_req(16'd0));
    send_backlog.push_back(wait_req(16'd1));
    send_backlog.push_back(wait_req(16'hFFFF));
    for (k = 0; k < 15; k++) begin
      send_backlog.push_back(add_req(ID_W'(16'h0010 + k), 32'd300 * k + 32'd7, 32'd7));
    end
    send_backlog.push_back(add_req(16'hAAAA, 32'd5, 32'd0));
    wait_idle();
    flush_queue();

    run_phase('0, 1000, 5, STYLE_PLAIN);
    run_phase(32'd1, 24, 20, STYLE_PLAIN);
    mid_bw = $urandom_range(512, 8192);
    run_phase(mid_bw, mid_bw * 6, 4, STYLE_LONG_STALL);
    run_phase($urandom, 32'hFFFF_FFFF, 3, STYLE_NO_IDLE);
    run_phase(BW_MAX, 32'hFFFF_FFFF, 1, STYLE_PLAIN);

    repeat (3 * SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d requests and checked %0d results under %0d bandwidth settings.",
             requests_taken, results_checked, bw_writes + 1);
    $display("Saw %0d completed transfers, %0d rejected adds, up to %0d results per wait.",
             completions, rejections, longest_run);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
